FILE: hw/rtl/ofv_pkg.sv
package ofv_pkg;

  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS  = 31;
  localparam int UNIT_LAT   = 5 + SQRT_STEPS + 1 + DIV_STEPS + 1;
  localparam int CROSS_LAT  = 2;
  localparam int A_LAT      = UNIT_LAT + CROSS_LAT;

  localparam logic [63:0] ONE_Q30  = 64'd1 << 30;
  localparam logic [63:0] HALF_Q30 = 64'd1 << 29;

  typedef logic [2:0][31:0] vec32_t;
  typedef logic [2:0][63:0] vec64_t;

endpackage

FILE: hw/rtl/ofv_unit.sv
module ofv_unit import ofv_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_valid,
  input  vec64_t in_v,
  output logic   out_valid,
  output vec32_t out_u,
  output logic   out_zero
);

  // magnitude and sign
  logic               s1_v_r;
  logic [2:0][63:0]   s1_mag_r;
  logic [2:0]         s1_neg_r;

  // leading one of the largest magnitude
  logic               s2_v_r;
  logic [2:0][63:0]   s2_mag_r;
  logic [2:0]         s2_neg_r;
  logic [5:0]         s2_msb_r;
  logic               s2_zero_r;
  logic [63:0]        big;
  logic [5:0]         msb_nxt;

  // normalised magnitudes
  logic               s3_v_r;
  logic [2:0][30:0]   s3_mn_r;
  logic [2:0]         s3_neg_r;
  logic               s3_zero_r;
  logic [2:0][30:0]   mn_nxt;

  // squares
  logic               s4_v_r;
  logic [2:0][61:0]   s4_sq_r;
  logic [2:0][30:0]   s4_mn_r;
  logic [2:0]         s4_neg_r;
  logic               s4_zero_r;

  // square root pipeline, entry 0 holds the sum of squares
  logic [SQRT_STEPS:0] sq_v_r;
  logic [SQRT_STEPS:0] sq_z_r;
  logic [63:0]         sq_s_r    [SQRT_STEPS+1];
  logic [32:0]         sq_rem_r  [SQRT_STEPS+1];
  logic [31:0]         sq_root_r [SQRT_STEPS+1];
  logic [2:0][30:0]    sq_mn_r   [SQRT_STEPS+1];
  logic [2:0]          sq_neg_r  [SQRT_STEPS+1];
  logic [32:0]         sq_rem_nxt  [SQRT_STEPS];
  logic [31:0]         sq_root_nxt [SQRT_STEPS];

  // divider pipeline, entry 0 is the set-up stage
  logic [DIV_STEPS:0]  dv_v_r;
  logic [DIV_STEPS:0]  dv_z_r;
  logic [31:0]         dv_den_r [DIV_STEPS+1];
  logic [2:0][32:0]    dv_rem_r [DIV_STEPS+1];
  logic [2:0][30:0]    dv_nlo_r [DIV_STEPS+1];
  logic [2:0][30:0]    dv_q_r   [DIV_STEPS+1];
  logic [2:0]          dv_neg_r [DIV_STEPS+1];
  logic [2:0][32:0]    dv_rem_nxt [DIV_STEPS];
  logic [2:0][30:0]    dv_q_nxt   [DIV_STEPS];
  logic [2:0][61:0]    num;

  logic               out_v_r;
  vec32_t             out_u_r;
  logic               out_z_r;

  always_comb begin
    big = s1_mag_r[0] | s1_mag_r[1] | s1_mag_r[2];
    msb_nxt = '0;
    for (int b = 0; b < 64; b++) begin
      if (big[b]) msb_nxt = 6'(b);
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (s2_msb_r >= 6'd30) begin
        mn_nxt[i] = 31'(s2_mag_r[i] >> (s2_msb_r - 6'd30));
      end else begin
        mn_nxt[i] = 31'(s2_mag_r[i] << (6'd30 - s2_msb_r));
      end
    end
  end

  always_comb begin
    logic [34:0] remw;
    logic [34:0] trial;
    remw  = '0;
    trial = '0;
    for (int k = 0; k < SQRT_STEPS; k++) begin
      remw  = {sq_rem_r[k], sq_s_r[k][63:62]};
      trial = {1'b0, sq_root_r[k], 2'b01};
      if (remw >= trial) begin
        sq_rem_nxt[k]  = 33'(remw - trial);
        sq_root_nxt[k] = {sq_root_r[k][30:0], 1'b1};
      end else begin
        sq_rem_nxt[k]  = remw[32:0];
        sq_root_nxt[k] = {sq_root_r[k][30:0], 1'b0};
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      num[i] = {sq_mn_r[SQRT_STEPS][i], 31'd0} >> 1;
      num[i] = num[i] + 62'(sq_root_r[SQRT_STEPS] >> 1);
    end
  end

  always_comb begin
    logic [32:0] rw;
    rw = '0;
    for (int j = 0; j < DIV_STEPS; j++) begin
      for (int i = 0; i < 3; i++) begin
        rw = {dv_rem_r[j][i][31:0], dv_nlo_r[j][i][30]};
        if (rw >= {1'b0, dv_den_r[j]}) begin
          dv_rem_nxt[j][i] = rw - {1'b0, dv_den_r[j]};
          dv_q_nxt[j][i]   = {dv_q_r[j][i][29:0], 1'b1};
        end else begin
          dv_rem_nxt[j][i] = rw;
          dv_q_nxt[j][i]   = {dv_q_r[j][i][29:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      s4_v_r  <= 1'b0;
      sq_v_r  <= '0;
      dv_v_r  <= '0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r    <= in_valid;
      s2_v_r    <= s1_v_r;
      s3_v_r    <= s2_v_r;
      s4_v_r    <= s3_v_r;
      sq_v_r[0] <= s4_v_r;
      for (int k = 0; k < SQRT_STEPS; k++) sq_v_r[k+1] <= sq_v_r[k];
      dv_v_r[0] <= sq_v_r[SQRT_STEPS];
      for (int j = 0; j < DIV_STEPS; j++) dv_v_r[j+1] <= dv_v_r[j];
      out_v_r   <= dv_v_r[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      s1_neg_r[i] <= in_v[i][63];
      s1_mag_r[i] <= in_v[i][63] ? (~in_v[i] + 64'd1) : in_v[i];
    end
    s2_mag_r  <= s1_mag_r;
    s2_neg_r  <= s1_neg_r;
    s2_msb_r  <= msb_nxt;
    s2_zero_r <= (big == '0);

    s3_mn_r   <= mn_nxt;
    s3_neg_r  <= s2_neg_r;
    s3_zero_r <= s2_zero_r;

    for (int i = 0; i < 3; i++) s4_sq_r[i] <= s3_mn_r[i] * s3_mn_r[i];
    s4_mn_r   <= s3_mn_r;
    s4_neg_r  <= s3_neg_r;
    s4_zero_r <= s3_zero_r;

    sq_s_r[0]    <= {2'b0, s4_sq_r[0]} + {2'b0, s4_sq_r[1]} + {2'b0, s4_sq_r[2]};
    sq_rem_r[0]  <= '0;
    sq_root_r[0] <= '0;
    sq_mn_r[0]   <= s4_mn_r;
    sq_neg_r[0]  <= s4_neg_r;
    sq_z_r[0]    <= s4_zero_r;
    for (int k = 0; k < SQRT_STEPS; k++) begin
      sq_s_r[k+1]    <= {sq_s_r[k][61:0], 2'b00};
      sq_rem_r[k+1]  <= sq_rem_nxt[k];
      sq_root_r[k+1] <= sq_root_nxt[k];
      sq_mn_r[k+1]   <= sq_mn_r[k];
      sq_neg_r[k+1]  <= sq_neg_r[k];
      sq_z_r[k+1]    <= sq_z_r[k];
    end

    dv_den_r[0] <= sq_root_r[SQRT_STEPS];
    dv_neg_r[0] <= sq_neg_r[SQRT_STEPS];
    dv_z_r[0]   <= sq_z_r[SQRT_STEPS];
    for (int i = 0; i < 3; i++) begin
      dv_rem_r[0][i] <= {2'b00, num[i][61:31]};
      dv_nlo_r[0][i] <= num[i][30:0];
      dv_q_r[0][i]   <= '0;
    end
    for (int j = 0; j < DIV_STEPS; j++) begin
      dv_den_r[j+1] <= dv_den_r[j];
      dv_neg_r[j+1] <= dv_neg_r[j];
      dv_z_r[j+1]   <= dv_z_r[j];
      dv_rem_r[j+1] <= dv_rem_nxt[j];
      dv_q_r[j+1]   <= dv_q_nxt[j];
      for (int i = 0; i < 3; i++) dv_nlo_r[j+1][i] <= {dv_nlo_r[j][i][29:0], 1'b0};
    end

    for (int i = 0; i < 3; i++) begin
      if (dv_z_r[DIV_STEPS]) begin
        out_u_r[i] <= '0;
      end else if (dv_neg_r[DIV_STEPS][i]) begin
        out_u_r[i] <= 32'd0 - {1'b0, dv_q_r[DIV_STEPS][i]};
      end else begin
        out_u_r[i] <= {1'b0, dv_q_r[DIV_STEPS][i]};
      end
    end
    out_z_r <= dv_z_r[DIV_STEPS];
  end

  assign out_valid = out_v_r;
  assign out_u     = out_u_r;
  assign out_zero  = out_z_r;

endmodule

FILE: hw/rtl/orthonormal_frame_from_two_vectors.sv
// Fully pipelined frame builder: one vector pair may be started in every cycle and busy
// stays low. Results appear on out_valid in the order of their starts; the latency is
// set by the two normalisation units (each a 32-stage square root and a 31-stage
// divider) plus the product and difference registers of each cross product and the
// rounding register. The receiver cannot stall, so every result must be captured in the
// cycle it is shown.
module orthonormal_frame_from_two_vectors import ofv_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_first_x,
  input  logic [31:0] in_first_y,
  input  logic [31:0] in_first_z,
  input  logic [31:0] in_second_x,
  input  logic [31:0] in_second_y,
  input  logic [31:0] in_second_z,
  output logic        out_valid,
  output logic [31:0] out_axis_a_x,
  output logic [31:0] out_axis_a_y,
  output logic [31:0] out_axis_a_z,
  output logic [31:0] out_axis_b_x,
  output logic [31:0] out_axis_b_y,
  output logic [31:0] out_axis_b_z,
  output logic [31:0] out_axis_c_x,
  output logic [31:0] out_axis_c_y,
  output logic [31:0] out_axis_c_z,
  output logic        out_degenerate
);

  vec64_t ua_in;
  logic   ua_valid;
  vec32_t ua_u;
  logic   ua_zero;

  vec32_t v2_d_r [UNIT_LAT];
  vec32_t a_d_r  [A_LAT];
  logic   za_d_r [A_LAT];

  logic                     x1_v_r;
  logic signed [63:0]       x1_p_r [6];
  logic                     x2_v_r;
  vec64_t                   x2_t_r;
  vec32_t                   v2;

  logic   ub_valid;
  vec32_t ub_u;
  logic   ub_zero;

  logic               y1_v_r;
  logic signed [63:0] y1_p_r [6];
  vec32_t             y1_a_r, y1_b_r;
  logic               y1_ok_r;
  logic               y2_v_r;
  logic signed [63:0] y2_c_r [3];
  vec32_t             y2_a_r, y2_b_r;
  logic               y2_ok_r;

  logic               out_v_r;
  vec32_t             out_a_r, out_b_r, out_c_r;
  logic               out_deg_r;
  logic [63:0]        cmag [3];
  logic [63:0]        crnd [3];
  logic [31:0]        cq30 [3];

  assign busy = 1'b0;

  assign ua_in[0] = {{32{in_first_x[31]}}, in_first_x};
  assign ua_in[1] = {{32{in_first_y[31]}}, in_first_y};
  assign ua_in[2] = {{32{in_first_z[31]}}, in_first_z};

  ofv_unit u_unit_a (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (start),
    .in_v      (ua_in),
    .out_valid (ua_valid),
    .out_u     (ua_u),
    .out_zero  (ua_zero)
  );

  assign v2 = v2_d_r[UNIT_LAT-1];

  always_ff @(posedge clk) begin
    v2_d_r[0] <= {in_second_z, in_second_y, in_second_x};
    for (int k = 1; k < UNIT_LAT; k++) v2_d_r[k] <= v2_d_r[k-1];
    a_d_r[0]  <= ua_u;
    za_d_r[0] <= ua_zero;
    for (int k = 1; k < A_LAT; k++) begin
      a_d_r[k]  <= a_d_r[k-1];
      za_d_r[k] <= za_d_r[k-1];
    end

    // second vector cross first axis
    x1_p_r[0] <= $signed(v2[1]) * $signed(ua_u[2]);
    x1_p_r[1] <= $signed(v2[2]) * $signed(ua_u[1]);
    x1_p_r[2] <= $signed(v2[2]) * $signed(ua_u[0]);
    x1_p_r[3] <= $signed(v2[0]) * $signed(ua_u[2]);
    x1_p_r[4] <= $signed(v2[0]) * $signed(ua_u[1]);
    x1_p_r[5] <= $signed(v2[1]) * $signed(ua_u[0]);
    x2_t_r[0] <= x1_p_r[0] - x1_p_r[1];
    x2_t_r[1] <= x1_p_r[2] - x1_p_r[3];
    x2_t_r[2] <= x1_p_r[4] - x1_p_r[5];

    // first axis cross second axis
    y1_p_r[0] <= $signed(a_d_r[A_LAT-1][1]) * $signed(ub_u[2]);
    y1_p_r[1] <= $signed(a_d_r[A_LAT-1][2]) * $signed(ub_u[1]);
    y1_p_r[2] <= $signed(a_d_r[A_LAT-1][2]) * $signed(ub_u[0]);
    y1_p_r[3] <= $signed(a_d_r[A_LAT-1][0]) * $signed(ub_u[2]);
    y1_p_r[4] <= $signed(a_d_r[A_LAT-1][0]) * $signed(ub_u[1]);
    y1_p_r[5] <= $signed(a_d_r[A_LAT-1][1]) * $signed(ub_u[0]);
    y1_a_r    <= a_d_r[A_LAT-1];
    y1_b_r    <= ub_u;
    y1_ok_r   <= !za_d_r[A_LAT-1] && !ub_zero;

    y2_c_r[0] <= y1_p_r[0] - y1_p_r[1];
    y2_c_r[1] <= y1_p_r[2] - y1_p_r[3];
    y2_c_r[2] <= y1_p_r[4] - y1_p_r[5];
    y2_a_r    <= y1_a_r;
    y2_b_r    <= y1_b_r;
    y2_ok_r   <= y1_ok_r;

    for (int i = 0; i < 3; i++) begin
      out_a_r[i] <= y2_ok_r ? y2_a_r[i] : '0;
      out_b_r[i] <= y2_ok_r ? y2_b_r[i] : '0;
      out_c_r[i] <= y2_ok_r ? cq30[i] : '0;
    end
    out_deg_r <= !y2_ok_r;
  end

  // round half away from zero to q1.30, saturating at one
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cmag[i] = y2_c_r[i][63] ? (64'd0 - y2_c_r[i]) : y2_c_r[i];
      crnd[i] = (cmag[i] + HALF_Q30) >> 30;
      if (crnd[i] > ONE_Q30) crnd[i] = ONE_Q30;
      cq30[i] = y2_c_r[i][63] ? (32'd0 - crnd[i][31:0]) : crnd[i][31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x1_v_r  <= 1'b0;
      x2_v_r  <= 1'b0;
      y1_v_r  <= 1'b0;
      y2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      x1_v_r  <= ua_valid;
      x2_v_r  <= x1_v_r;
      y1_v_r  <= ub_valid;
      y2_v_r  <= y1_v_r;
      out_v_r <= y2_v_r;
    end
  end

  ofv_unit u_unit_b (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (x2_v_r),
    .in_v      (x2_t_r),
    .out_valid (ub_valid),
    .out_u     (ub_u),
    .out_zero  (ub_zero)
  );

  assign out_valid      = out_v_r;
  assign out_axis_a_x   = out_a_r[0];
  assign out_axis_a_y   = out_a_r[1];
  assign out_axis_a_z   = out_a_r[2];
  assign out_axis_b_x   = out_b_r[0];
  assign out_axis_b_y   = out_b_r[1];
  assign out_axis_b_z   = out_b_r[2];
  assign out_axis_c_x   = out_c_r[0];
  assign out_axis_c_y   = out_c_r[1];
  assign out_axis_c_z   = out_c_r[2];
  assign out_degenerate = out_deg_r;

endmodule
